FILE: rtl/core/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg
// Shared types and constants of the segment versus spike triangle unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sti_pkg;

  // field widths
  localparam int COORD_W    = 16;
  localparam int SIZE_W     = 12;
  localparam int AMT_W      = 8;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // datapath widths
  localparam int EDGE_COUNT = 3;
  localparam int PT_W       = 18;   // edge corner coordinates
  localparam int DEL_W      = 13;   // edge deltas
  localparam int SD_W       = 17;   // segment deltas
  localparam int A_W        = 33;   // segment cross term
  localparam int B_W        = 32;   // edge cross term
  localparam int DET_W      = 31;   // determinant, signed
  localparam int DM_W       = 32;   // determinant magnitude, held signed
  localparam int NW         = 52;   // numerators and bound products
  localparam int DW         = 31;   // divisor
  localparam int QW         = 33;   // quotient bits of n*256/d
  localparam int RW         = DW + QW;
  localparam int FRAC       = 8;

  localparam int MISS_COORD = -9999;
  localparam logic signed [OUT_W-1:0] MISS_Q8 = OUT_W'(MISS_COORD * 256);
  localparam logic signed [OUT_W-1:0] Q8_MAX  = 32'sh7fff_ffff;
  localparam logic signed [OUT_W-1:0] Q8_MIN  = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_X     = 3'd0,
    CFG_BOX_Y     = 3'd1,
    CFG_BOX_W     = 3'd2,
    CFG_BOX_H     = 3'd3,
    CFG_DAMAGE    = 3'd4,
    CFG_KNOCKBACK = 3'd5,
    CFG_INVULN    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] seg_start_x;
    logic signed [COORD_W-1:0] seg_start_y;
    logic signed [COORD_W-1:0] seg_end_x;
    logic signed [COORD_W-1:0] seg_end_y;
  } seg_t;

  typedef struct packed {
    logic                    hit;
    logic signed [OUT_W-1:0] hit_x;
    logic signed [OUT_W-1:0] hit_y;
    logic [AMT_W-1:0]        damage_out;
    logic [AMT_W-1:0]        knockback_out;
    logic [AMT_W-1:0]        invuln_out;
  } res_t;

  // one stage of the restoring divider, both coordinates side by side
  typedef struct packed {
    logic          vld;
    logic          hit;
    logic          neg_x;
    logic          neg_y;
    logic          ovf_x;
    logic          ovf_y;
    logic [DW-1:0] d;
    logic [RW-1:0] rem_x;
    logic [RW-1:0] rem_y;
    logic [QW-1:0] q_x;
    logic [QW-1:0] q_y;
  } div_stage_t;

endpackage

`default_nettype wire

FILE: rtl/core/segment_triangle_intersect_unit.sv
// ----------------------------------------------------------------------------
// segment_triangle_intersect_unit
// Line segment versus spike triangle edge intersection, fully pipelined.
// ----------------------------------------------------------------------------
// path: front stages, divider entry register, divider stages, then the result register
// throughput: one item per cycle while not stalled; the 33 stage restoring divider takes a bit a stage
// stall: the whole pipeline holds while a result waits under res_stall
// reset: synchronous, clears all valid bits and the configuration registers to zero
`default_nettype none

module segment_triangle_intersect_unit import sti_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  seg_valid,
  output logic                  seg_stall,
  input  seg_t                  seg,
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_t                  res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic signed [COORD_W-1:0] box_x;
  logic signed [COORD_W-1:0] box_y;
  logic [SIZE_W-1:0]         box_width;
  logic [SIZE_W-1:0]         box_height;
  logic [AMT_W-1:0]          damage_amount;
  logic [AMT_W-1:0]          knockback_amount;
  logic [AMT_W-1:0]          invuln_frames;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x            <= '0;
      box_y            <= '0;
      box_width        <= '0;
      box_height       <= '0;
      damage_amount    <= '0;
      knockback_amount <= '0;
      invuln_frames    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BOX_X:     box_x            <= signed'(cfg_data);
        CFG_BOX_Y:     box_y            <= signed'(cfg_data);
        CFG_BOX_W:     box_width        <= cfg_data[SIZE_W-1:0];
        CFG_BOX_H:     box_height       <= cfg_data[SIZE_W-1:0];
        CFG_DAMAGE:    damage_amount    <= cfg_data[AMT_W-1:0];
        CFG_KNOCKBACK: knockback_amount <= cfg_data[AMT_W-1:0];
        CFG_INVULN:    invuln_frames    <= cfg_data[AMT_W-1:0];
        default: ;
      endcase
    end
  end

  // triangle geometry, straight from the box registers
  // the user must change config only while nothing is in flight (not enforced here), so every stage may read it
  logic signed [PT_W-1:0]  bx, by, wx, hy, ax, ly, rx;
  logic signed [PT_W-1:0]  e_x3 [EDGE_COUNT];
  logic signed [PT_W-1:0]  e_y3 [EDGE_COUNT];
  logic signed [PT_W-1:0]  e_x4 [EDGE_COUNT];
  logic signed [PT_W-1:0]  e_y4 [EDGE_COUNT];
  logic signed [DEL_W-1:0] e_ex [EDGE_COUNT];
  logic signed [DEL_W-1:0] e_ey [EDGE_COUNT];
  logic signed [PT_W-1:0]  e_lox [EDGE_COUNT];
  logic signed [PT_W-1:0]  e_hix [EDGE_COUNT];
  logic signed [PT_W-1:0]  e_loy [EDGE_COUNT];
  logic signed [PT_W-1:0]  e_hiy [EDGE_COUNT];

  always_comb begin
    logic signed [PT_W-1:0] tx, ty;
    bx = PT_W'(box_x);
    by = PT_W'(box_y);
    wx = signed'(PT_W'(box_width));
    hy = signed'(PT_W'(box_height));
    ax = bx + (wx >>> 1);
    ly = by + hy;
    rx = bx + wx;
    // left-apex, right-apex, base
    e_x3[0] = bx; e_y3[0] = ly; e_x4[0] = ax; e_y4[0] = by;
    e_x3[1] = rx; e_y3[1] = ly; e_x4[1] = ax; e_y4[1] = by;
    e_x3[2] = bx; e_y3[2] = ly; e_x4[2] = rx; e_y4[2] = ly;
    for (int e = 0; e < EDGE_COUNT; e++) begin
      tx = e_x3[e] - e_x4[e];
      ty = e_y3[e] - e_y4[e];
      e_ex[e]  = tx[DEL_W-1:0];
      e_ey[e]  = ty[DEL_W-1:0];
      e_lox[e] = (e_x3[e] < e_x4[e]) ? e_x3[e] : e_x4[e];
      e_hix[e] = (e_x3[e] < e_x4[e]) ? e_x4[e] : e_x3[e];
      e_loy[e] = (e_y3[e] < e_y4[e]) ? e_y3[e] : e_y4[e];
      e_hiy[e] = (e_y3[e] < e_y4[e]) ? e_y4[e] : e_y3[e];
    end
  end

  // one global advance: the pipeline moves unless a result is held
  logic adv;
  assign adv       = !(res_valid && res_stall);
  assign seg_stall = !adv;

  // stage 1: segment, deltas, bounding box
  logic                      s1_vld;
  logic signed [COORD_W-1:0] s1_x1, s1_y1, s1_x2, s1_y2;
  logic signed [SD_W-1:0]    s1_dx, s1_dy;
  logic signed [COORD_W-1:0] s1_lox, s1_hix, s1_loy, s1_hiy;

  // stage 2: determinants and cross terms
  logic                      s2_vld;
  logic signed [A_W-1:0]     s2_a;
  logic signed [SD_W-1:0]    s2_dx, s2_dy;
  logic signed [DET_W-1:0]   s2_d [EDGE_COUNT];
  logic signed [B_W-1:0]     s2_b [EDGE_COUNT];
  logic signed [COORD_W-1:0] s2_lox, s2_hix, s2_loy, s2_hiy;

  // stage 3: numerators
  logic                      s3_vld;
  logic signed [DET_W-1:0]   s3_d  [EDGE_COUNT];
  logic signed [NW-1:0]      s3_nx [EDGE_COUNT];
  logic signed [NW-1:0]      s3_ny [EDGE_COUNT];
  logic signed [COORD_W-1:0] s3_lox, s3_hix, s3_loy, s3_hiy;

  // stage 4: make the determinant positive
  logic                      s4_vld;
  logic signed [DM_W-1:0]    s4_dm [EDGE_COUNT];
  logic                      s4_nz [EDGE_COUNT];
  logic signed [NW-1:0]      s4_nx [EDGE_COUNT];
  logic signed [NW-1:0]      s4_ny [EDGE_COUNT];
  logic signed [COORD_W-1:0] s4_lox, s4_hix, s4_loy, s4_hiy;

  // stage 5: bounds scaled by the determinant
  logic                      s5_vld;
  logic signed [DM_W-1:0]    s5_dm  [EDGE_COUNT];
  logic                      s5_nz  [EDGE_COUNT];
  logic signed [NW-1:0]      s5_nx  [EDGE_COUNT];
  logic signed [NW-1:0]      s5_ny  [EDGE_COUNT];
  logic signed [NW-1:0]      s5_slx [EDGE_COUNT];
  logic signed [NW-1:0]      s5_shx [EDGE_COUNT];
  logic signed [NW-1:0]      s5_sly [EDGE_COUNT];
  logic signed [NW-1:0]      s5_shy [EDGE_COUNT];
  logic signed [NW-1:0]      s5_elx [EDGE_COUNT];
  logic signed [NW-1:0]      s5_ehx [EDGE_COUNT];
  logic signed [NW-1:0]      s5_ely [EDGE_COUNT];
  logic signed [NW-1:0]      s5_ehy [EDGE_COUNT];

  // stage 6: first hitting edge
  logic                      s6_vld;
  logic                      s6_hit;
  logic signed [NW-1:0]      s6_nx, s6_ny;
  logic [DW-1:0]             s6_d;

  function automatic logic in_span(input logic signed [NW-1:0] n,
                                   input logic signed [NW-1:0] lo_p,
                                   input logic signed [NW-1:0] hi_p);
    return (lo_p <= n) && (n <= hi_p);
  endfunction

  logic                 lane_hit [EDGE_COUNT];
  logic                 sel_hit;
  logic signed [NW-1:0] sel_nx, sel_ny;
  logic [DW-1:0]        sel_d;

  always_comb begin
    sel_hit = 1'b0;
    sel_nx  = '0;
    sel_ny  = '0;
    sel_d   = '0;
    for (int e = 0; e < EDGE_COUNT; e++) begin
      lane_hit[e] = s5_nz[e] &&
                    in_span(s5_nx[e], s5_slx[e], s5_shx[e]) &&
                    in_span(s5_ny[e], s5_sly[e], s5_shy[e]) &&
                    in_span(s5_nx[e], s5_elx[e], s5_ehx[e]) &&
                    in_span(s5_ny[e], s5_ely[e], s5_ehy[e]);
    end
    // lowest edge wins
    for (int e = EDGE_COUNT - 1; e >= 0; e--) begin
      if (lane_hit[e]) begin
        sel_hit = 1'b1;
        sel_nx  = s5_nx[e];
        sel_ny  = s5_ny[e];
        sel_d   = s5_dm[e][DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= seg_valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      s1_x1  <= seg.seg_start_x;
      s1_y1  <= seg.seg_start_y;
      s1_x2  <= seg.seg_end_x;
      s1_y2  <= seg.seg_end_y;
      s1_dx  <= SD_W'(seg.seg_start_x) - SD_W'(seg.seg_end_x);
      s1_dy  <= SD_W'(seg.seg_start_y) - SD_W'(seg.seg_end_y);
      s1_lox <= (seg.seg_start_x < seg.seg_end_x) ? seg.seg_start_x : seg.seg_end_x;
      s1_hix <= (seg.seg_start_x < seg.seg_end_x) ? seg.seg_end_x : seg.seg_start_x;
      s1_loy <= (seg.seg_start_y < seg.seg_end_y) ? seg.seg_start_y : seg.seg_end_y;
      s1_hiy <= (seg.seg_start_y < seg.seg_end_y) ? seg.seg_end_y : seg.seg_start_y;
      // stage 2
      s2_a   <= s1_x1 * s1_y2 - s1_y1 * s1_x2;
      s2_dx  <= s1_dx;
      s2_dy  <= s1_dy;
      s2_lox <= s1_lox;
      s2_hix <= s1_hix;
      s2_loy <= s1_loy;
      s2_hiy <= s1_hiy;
      // stage 3
      s3_lox <= s2_lox;
      s3_hix <= s2_hix;
      s3_loy <= s2_loy;
      s3_hiy <= s2_hiy;
      // stage 4
      s4_lox <= s3_lox;
      s4_hix <= s3_hix;
      s4_loy <= s3_loy;
      s4_hiy <= s3_hiy;
      for (int e = 0; e < EDGE_COUNT; e++) begin
        s2_d[e]  <= s1_dx * e_ey[e] - s1_dy * e_ex[e];
        // x3*y4 - y3*x4 rewritten on the edge deltas
        s2_b[e]  <= e_y3[e] * e_ex[e] - e_x3[e] * e_ey[e];
        s3_d[e]  <= s2_d[e];
        s3_nx[e] <= s2_a * e_ex[e] - s2_dx * s2_b[e];
        s3_ny[e] <= s2_a * e_ey[e] - s2_dy * s2_b[e];
        s4_nz[e] <= |s3_d[e];
        if (s3_d[e][DET_W-1]) begin
          s4_dm[e] <= -DM_W'(s3_d[e]);
          s4_nx[e] <= -s3_nx[e];
          s4_ny[e] <= -s3_ny[e];
        end else begin
          s4_dm[e] <= DM_W'(s3_d[e]);
          s4_nx[e] <= s3_nx[e];
          s4_ny[e] <= s3_ny[e];
        end
        // stage 5
        s5_dm[e]  <= s4_dm[e];
        s5_nz[e]  <= s4_nz[e];
        s5_nx[e]  <= s4_nx[e];
        s5_ny[e]  <= s4_ny[e];
        s5_slx[e] <= s4_lox * s4_dm[e];
        s5_shx[e] <= s4_hix * s4_dm[e];
        s5_sly[e] <= s4_loy * s4_dm[e];
        s5_shy[e] <= s4_hiy * s4_dm[e];
        s5_elx[e] <= e_lox[e] * s4_dm[e];
        s5_ehx[e] <= e_hix[e] * s4_dm[e];
        s5_ely[e] <= e_loy[e] * s4_dm[e];
        s5_ehy[e] <= e_hiy[e] * s4_dm[e];
      end
      // stage 6
      s6_hit <= sel_hit;
      s6_nx  <= sel_nx;
      s6_ny  <= sel_ny;
      s6_d   <= sel_d;
    end
  end

  // divider entry: sign, magnitude, overflow when |n| >= d * 2^25
  div_stage_t           div_pipe [QW+1];
  div_stage_t           div_in;
  logic [NW-1:0]        mag_x, mag_y;
  logic [RW-1:0]        ovf_lim;

  always_comb begin
    mag_x   = s6_nx[NW-1] ? unsigned'(-s6_nx) : unsigned'(s6_nx);
    mag_y   = s6_ny[NW-1] ? unsigned'(-s6_ny) : unsigned'(s6_ny);
    ovf_lim = RW'(s6_d) << (QW - FRAC);
    div_in.vld   = s6_vld;
    div_in.hit   = s6_hit;
    div_in.neg_x = s6_nx[NW-1];
    div_in.neg_y = s6_ny[NW-1];
    div_in.ovf_x = RW'(mag_x) >= ovf_lim;
    div_in.ovf_y = RW'(mag_y) >= ovf_lim;
    div_in.d     = s6_d;
    div_in.rem_x = RW'(mag_x) << FRAC;
    div_in.rem_y = RW'(mag_y) << FRAC;
    div_in.q_x   = '0;
    div_in.q_y   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_pipe[0].vld <= 1'b0;
    end else if (adv) begin
      div_pipe[0] <= div_in;
    end
  end

  // restoring division, one quotient bit of n*256/d per stage, msb first
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int SH = QW - 1 - k;
    div_stage_t       nxt;
    logic [RW:0]      dv, tx, ty;

    always_comb begin
      nxt = div_pipe[k];
      dv  = {1'b0, RW'(div_pipe[k].d)} << SH;
      tx  = {1'b0, div_pipe[k].rem_x} - dv;
      ty  = {1'b0, div_pipe[k].rem_y} - dv;
      if (!tx[RW]) begin
        nxt.rem_x    = tx[RW-1:0];
        nxt.q_x[SH]  = 1'b1;
      end
      if (!ty[RW]) begin
        nxt.rem_y    = ty[RW-1:0];
        nxt.q_y[SH]  = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_pipe[k+1].vld <= 1'b0;
      end else if (adv) begin
        div_pipe[k+1] <= nxt;
      end
    end
  end

  // sign and saturate to Q23.8
  function automatic logic signed [OUT_W-1:0] q8_sat(input logic [QW-1:0] q,
                                                      input logic neg,
                                                      input logic ovf);
    logic big;
    big = ovf | (|q[QW-1:OUT_W-1]);
    if (neg) begin
      return big ? Q8_MIN : -signed'(q[OUT_W-1:0]);
    end
    return big ? Q8_MAX : signed'(q[OUT_W-1:0]);
  endfunction

  div_stage_t last;
  assign last = div_pipe[QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.hit           <= last.hit;
      res.hit_x         <= last.hit ? q8_sat(last.q_x, last.neg_x, last.ovf_x) : MISS_Q8;
      res.hit_y         <= last.hit ? q8_sat(last.q_y, last.neg_y, last.ovf_y) : MISS_Q8;
      res.damage_out    <= damage_amount;
      res.knockback_out <= knockback_amount;
      res.invuln_out    <= invuln_frames;
    end
  end

  // a miss always carries the miss point
  a_miss_point: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.hit) |-> (res.hit_x == MISS_Q8 && res.hit_y == MISS_Q8))
    else $error("miss result without miss point");

  // an item in the select stage reaches the divider entry
  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    (adv && s6_vld) |=> div_pipe[0].vld)
    else $error("item lost at divider entry");

  // a held pipeline keeps its valid bits
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(s1_vld) && $stable(div_pipe[QW].vld) && res_valid))
    else $error("pipeline moved while held");

endmodule

`default_nettype wire
